>>> rtl/lcr_pkg.sv
// Shared types, register map and constants for the load cell reader.
`default_nettype none

package lcr_pkg;

   // converter word width default
   localparam int DATA_BITS_DEF = 24;

   // field widths fixed by the register map and result format
   localparam int DIV_W   = 16;
   localparam int LIM_W   = 16;
   localparam int TOL_W   = 24;
   localparam int WGT_W   = 16;
   localparam int RAW_W   = 24;
   localparam int DEN_W   = DIV_W + 5;
   localparam int ADDR_W  = 4;
   localparam int PDATA_W = 32;

   // register reset values
   localparam logic [DIV_W-1:0] DIVISOR_RST   = DIV_W'(415);
   localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(20000);
   localparam logic [TOL_W-1:0] TOLERANCE_RST = TOL_W'(3000);

   // register indexes (word address paddr[3:2])
   localparam logic [1:0] REG_SCALE_DIVISOR  = 2'd0;
   localparam logic [1:0] REG_OVERLOAD_LIMIT = 2'd1;
   localparam logic [1:0] REG_TARE_TOLERANCE = 2'd2;

   // request action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WEIGH = 2'd1;
   localparam logic [1:0] ACT_TARE  = 2'd2;

   typedef struct packed {
      logic [DIV_W-1:0] scale_divisor;
      logic [LIM_W-1:0] overload_limit;
      logic [TOL_W-1:0] tare_tolerance;
   } cfg_type;

   typedef struct packed {
      logic emit;        // load result register
      logic start;       // begin a read sequence
      logic tare_sel;    // sequence is a tare
      logic shift;       // shift in one data bit
      logic shift_bit;
      logic tare_load;   // store raw as tare
      logic div_start;   // launch weight division
      logic weigh_load;  // update weight and error
      logic clock_line;
      logic busy;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic last_bit;
      logic tare_mode;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/lcr_csr.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module lcr_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lcr_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [lcr_pkg::PDATA_W-1:0]   pwdata,
   output logic      [lcr_pkg::PDATA_W-1:0]   prdata,
   output logic                               pready,
   output lcr_pkg::cfg_type                   cfg
);
   import lcr_pkg::*;

   logic [DIV_W-1:0] divisor_ff, divisor_in;
   logic [LIM_W-1:0] limit_ff, limit_in;
   logic [TOL_W-1:0] tolerance_ff, tolerance_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      divisor_in   = divisor_ff;
      limit_in     = limit_ff;
      tolerance_in = tolerance_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_SCALE_DIVISOR:  divisor_in   = pwdata[DIV_W-1:0];
            REG_OVERLOAD_LIMIT: limit_in     = pwdata[LIM_W-1:0];
            REG_TARE_TOLERANCE: tolerance_in = pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= DIVISOR_RST;
         limit_ff     <= LIMIT_RST;
         tolerance_ff <= TOLERANCE_RST;
      end else begin
         divisor_ff   <= divisor_in;
         limit_ff     <= limit_in;
         tolerance_ff <= tolerance_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SCALE_DIVISOR:  prdata = PDATA_W'(divisor_ff);
         REG_OVERLOAD_LIMIT: prdata = PDATA_W'(limit_ff);
         REG_TARE_TOLERANCE: prdata = PDATA_W'(tolerance_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.scale_divisor  = divisor_ff;
   assign cfg.overload_limit = limit_ff;
   assign cfg.tare_tolerance = tolerance_ff;

endmodule

`default_nettype wire

>>> rtl/lcr_datapath.sv
// Datapath: shift register, tare, serial weight divider and result register.
`default_nettype none

module lcr_datapath #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lcr_pkg::cfg_type            cfg,
   input  wire lcr_pkg::cmd_type            cmd,
   output lcr_pkg::status_type              status,
   output logic                             rsp_clock_line,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [lcr_pkg::WGT_W-1:0]        rsp_weight,
   output logic                             rsp_error,
   output logic [lcr_pkg::RAW_W-1:0]        rsp_raw_value
);
   import lcr_pkg::*;

   localparam int CNT_W  = $clog2(DATA_BITS + 1);
   localparam int NUM_W  = ((DATA_BITS + 5 > WGT_W) ? DATA_BITS + 5 : WGT_W) + 1;
   localparam int DIVC_W = $clog2(NUM_W + 1);
   localparam int BAND_W = ((DATA_BITS > TOL_W) ? DATA_BITS : TOL_W) + 1;
   localparam logic [DATA_BITS-1:0] SIGN_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]     bit_count_ff, bit_count_in;
   logic [DATA_BITS-1:0] tare_ff, tare_in;
   logic [DATA_BITS-1:0] last_raw_ff, last_raw_in;
   logic [WGT_W-1:0]     held_ff, held_in;
   logic                 error_ff, error_in;
   logic                 tare_mode_ff, tare_mode_in;

   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIVC_W-1:0]    dcnt_ff, dcnt_in;
   logic                 div_busy_ff, div_busy_in;

   logic [DATA_BITS-1:0] raw;
   logic [DIV_W-1:0]     div_eff;
   logic [DATA_BITS-1:0] diff;
   logic [NUM_W-1:0]     diff_ext;
   logic [NUM_W-1:0]     num_start;
   logic [DEN_W-1:0]     div_ext;
   logic [DEN_W:0]       rem_sh;
   logic                 q_bit;
   logic                 raw_ge;
   logic                 in_band;
   logic                 over;
   logic [WGT_W-1:0]     sat_weight;

   assign raw      = shift_ff ^ SIGN_BIT;
   assign div_eff  = (cfg.scale_divisor == '0) ? DIV_W'(1) : cfg.scale_divisor;
   assign diff     = raw - tare_ff;
   assign diff_ext = NUM_W'(diff);
   assign num_start = (diff_ext << 4) + (diff_ext << 2) + NUM_W'(div_eff);
   assign div_ext  = DEN_W'(div_eff);

   // one restoring step per cycle
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, den_ff});

   assign raw_ge  = (raw >= tare_ff);
   assign in_band = ((BAND_W'(raw) + BAND_W'(cfg.tare_tolerance)) > BAND_W'(tare_ff));
   assign over    = (quo_ff > NUM_W'(cfg.overload_limit));
   assign sat_weight = (|quo_ff[NUM_W-1:WGT_W]) ? {WGT_W{1'b1}} : quo_ff[WGT_W-1:0];

   always_comb begin
      shift_in     = shift_ff;
      bit_count_in = bit_count_ff;
      tare_in      = tare_ff;
      last_raw_in  = last_raw_ff;
      held_in      = held_ff;
      error_in     = error_ff;
      tare_mode_in = tare_mode_ff;
      if (cmd.start) begin
         bit_count_in = '0;
         tare_mode_in = cmd.tare_sel;
      end
      if (cmd.shift) begin
         shift_in     = {shift_ff[DATA_BITS-2:0], cmd.shift_bit};
         bit_count_in = bit_count_ff + CNT_W'(1);
      end
      if (cmd.tare_load) begin
         tare_in     = raw;
         last_raw_in = raw;
      end
      if (cmd.weigh_load) begin
         last_raw_in = raw;
         if (raw_ge) begin
            error_in = over;
            held_in  = sat_weight;
         end else if (in_band) begin
            error_in = 1'b0;
            held_in  = '0;
         end else begin
            error_in = 1'b1;
         end
      end
   end

   always_comb begin
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      dcnt_in     = dcnt_ff;
      div_busy_in = div_busy_ff;
      if (cmd.div_start) begin
         quo_in      = num_start;
         rem_in      = '0;
         den_in      = (div_ext << 4) + (div_ext << 2);
         dcnt_in     = DIVC_W'(NUM_W);
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], q_bit};
         rem_in  = q_bit ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         dcnt_in = dcnt_ff - DIVC_W'(1);
         if (dcnt_ff == DIVC_W'(1)) begin
            div_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bit_count_ff <= '0;
         tare_ff      <= '0;
         last_raw_ff  <= '0;
         held_ff      <= '0;
         error_ff     <= 1'b0;
         tare_mode_ff <= 1'b0;
         div_busy_ff  <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         bit_count_ff <= bit_count_in;
         tare_ff      <= tare_in;
         last_raw_ff  <= last_raw_in;
         held_ff      <= held_in;
         error_ff     <= error_in;
         tare_mode_ff <= tare_mode_in;
         div_busy_ff  <= div_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      dcnt_ff <= dcnt_in;
      if (cmd.emit) begin
         rsp_clock_line <= cmd.clock_line;
         rsp_busy_res   <= cmd.busy;
         rsp_done_res   <= cmd.done;
         rsp_weight     <= held_in;
         rsp_error      <= error_in;
         rsp_raw_value  <= RAW_W'(last_raw_in);
      end
   end

   assign status.last_bit  = (bit_count_ff >= CNT_W'(DATA_BITS - 1));
   assign status.tare_mode = tare_mode_ff;
   assign status.div_done  = ~div_busy_ff;

endmodule

`default_nettype wire

>>> rtl/lcr_controller.sv
// Controller: request buffer, read sequence state machine, result handshake.
`default_nettype none

module lcr_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_action,
   input  wire logic                 req_data_line,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lcr_pkg::cmd_type          cmd,
   input  wire lcr_pkg::status_type  status
);
   import lcr_pkg::*;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_WAIT   = 6'b000010,
      PH_HIGH   = 6'b000100,
      PH_LOW    = 6'b001000,
      PH_EXTRA  = 6'b010000,
      PH_DIVIDE = 6'b100000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] action_ff;
   logic       data_ff;
   logic       accept;
   logic       slot_free;
   logic       commit;

   assign accept    = req_valid & ~pend_ff;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = pend_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      phase_in = phase_ff;
      commit   = 1'b0;
      cmd      = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (pend_ff && slot_free) begin
               commit = 1'b1;
               if (action_ff == ACT_WEIGH || action_ff == ACT_TARE) begin
                  cmd.start    = 1'b1;
                  cmd.tare_sel = (action_ff == ACT_TARE);
                  phase_in     = PH_WAIT;
               end
            end
         end
         PH_WAIT: begin
            if (pend_ff && slot_free) begin
               commit = 1'b1;
               if (!data_ff) begin
                  cmd.clock_line = 1'b1;
                  phase_in       = PH_HIGH;
               end
            end
         end
         PH_HIGH: begin
            if (pend_ff && slot_free) begin
               commit   = 1'b1;
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            if (pend_ff && slot_free) begin
               commit         = 1'b1;
               cmd.shift      = 1'b1;
               cmd.shift_bit  = data_ff;
               cmd.clock_line = 1'b1;
               phase_in       = status.last_bit ? PH_EXTRA : PH_HIGH;
            end
         end
         PH_EXTRA: begin
            if (pend_ff) begin
               if (status.tare_mode) begin
                  if (slot_free) begin
                     commit        = 1'b1;
                     cmd.tare_load = 1'b1;
                     cmd.done      = 1'b1;
                     phase_in      = PH_IDLE;
                  end
               end else begin
                  cmd.div_start = 1'b1;
                  phase_in      = PH_DIVIDE;
               end
            end
         end
         PH_DIVIDE: begin
            if (status.div_done && slot_free) begin
               commit         = 1'b1;
               cmd.weigh_load = 1'b1;
               cmd.done       = 1'b1;
               phase_in       = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      cmd.emit = commit;
      cmd.busy = (phase_in != PH_IDLE);
   end

   always_comb begin
      pend_in      = commit ? 1'b0 : (accept | pend_ff);
      rsp_valid_in = commit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the accepted request until its tick is applied
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         data_ff   <= req_data_line;
      end
   end

endmodule

`default_nettype wire

>>> rtl/load_cell_reader_with_tare.sv
// Top level of the load cell converter reader with tare.
//
// Each request is one half-period tick of the converter serial clock: an
// action code (tick, start weighing, start tare) and the sampled data line.
// Every request yields exactly one response carrying the clock level to
// drive, busy and done flags, the held weight, the error flag and the last
// raw conversion. A read waits for the data line to go low, clocks in
// DATA_BITS bits MSB first, adds one extra pulse, and on the final tick
// either stores the tare or computes the weight.
// A request is taken into a one-entry buffer, and its response is
// registered once the response slot is free. The final tick of a
// weighing runs a restoring divider at one quotient bit per cycle, with
// NUM_W = max(DATA_BITS+5,16)+1 steps (30 steps at 24 bits).
// The response register parts the two channels: a new request is taken
// while an earlier response is still stalled; the following tick then waits
// until the response slot frees. Reset clears the sequence to idle, zeroes
// tare, weight, error and raw value, and loads the register defaults.
// Registers: scale_divisor at 0x0, overload_limit at 0x4, tare_tolerance
// at 0x8; write only while idle.
`default_nettype none

module load_cell_reader_with_tare #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_action,
   input  wire logic                        req_data_line,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_clock_line,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [lcr_pkg::WGT_W-1:0]        rsp_weight,
   output logic                             rsp_error,
   output logic [lcr_pkg::RAW_W-1:0]        rsp_raw_value,
   // configuration port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [lcr_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [lcr_pkg::PDATA_W-1:0] pwdata,
   output logic      [lcr_pkg::PDATA_W-1:0] prdata,
   output logic                             pready
);
   import lcr_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // register file: hold divisor, limit and tolerance
   lcr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: advance the read phases and drive the handshakes
   lcr_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_line (req_data_line),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // datapath: shift in bits, divide, hold the response payload
   lcr_datapath #(
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .rsp_clock_line (rsp_clock_line),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_weight     (rsp_weight),
      .rsp_error      (rsp_error),
      .rsp_raw_value  (rsp_raw_value)
   );

endmodule

`default_nettype wire
